@@ rtl/core/ifmd_pkg.sv @@
`default_nettype none

package ifmd_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_RESET  = 2'd1,
        CMD_FETCH  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Addressing modes reported with a fetched instruction.
    typedef enum logic [1:0] {
        MODE_ZP    = 2'd0,
        MODE_IMM   = 2'd1,
        MODE_ABS   = 2'd2,
        MODE_UNSUP = 2'd3
    } mode_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MARK = 6'b000010,
        ST_OPC  = 6'b000100,
        ST_LO   = 6'b001000,
        ST_HI   = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam logic [7:0] END_MARKER = 8'hFF;
    localparam logic [7:0] IDLE_CODE  = 8'h85;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Addressing mode from the low nibble of the opcode.
    function automatic mode_t decode_mode(input logic [7:0] op);
        logic [3:0] nib;
        nib = op[3:0];
        if (nib >= 4'h4 && nib <= 4'h7) begin
            return MODE_ZP;
        end else if (nib == 4'h9 || nib == 4'hB) begin
            return MODE_IMM;
        end else if (nib >= 4'hC) begin
            return MODE_ABS;
        end else begin
            return MODE_UNSUP;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/instruction_fetch_with_mode_decode.sv @@
`default_nettype none

// Instruction fetch with addressing-mode decode. The block keeps a
// byte-wide program store of STORE_DEPTH entries and a fetch pointer. Each input
// transaction is a load (write one byte), a pointer reset or a fetch, and gives
// exactly one result transaction. The block takes one transaction at a time: a
// load, reset or unused command goes straight to the result; a fetch reads
// the opcode, then the low operand byte, then for absolute mode the high
// operand byte (an unsupported opcode reads the opcode only). An end marker
// read first wraps the pointer back to zero before the opcode is read.
// Reads come from the single-port program store, which returns one registered byte per cycle.
// The result is held on the output until taken, and the input is ready again
// in the cycle after that. Store entries must be loaded before they are
// fetched; the store has no reset.
module instruction_fetch_with_mode_decode
    import ifmd_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // Input channel.
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [1:0]            s_tuser,  // [1:0] command
    input  wire  [S_TDATA_W-1:0]  s_tdata,  // [11:0] load_address, [19:12] load_byte
    // Result channel.
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic                  m_tuser,  // [0] fetched
    output logic [M_TDATA_W-1:0]  m_tdata   // [7:0] opcode, [9:8] mode,
                                            // [17:10] operand_low, [25:18] operand_high
);

    localparam int PTR_W = $clog2(STORE_DEPTH);

    // Unpacked input fields.
    cmd_t        s_command;
    logic [11:0] s_load_address;
    logic [7:0]  s_load_byte;

    assign s_command      = cmd_t'(s_tuser);
    assign s_load_address = s_tdata[11:0];
    assign s_load_byte    = s_tdata[19:12];

    // Registers.
    state_t             state_reg,    state_next;
    logic [PTR_W-1:0]   ptr_reg,      ptr_next;
    logic               fetched_reg,  fetched_next;
    logic [7:0]         opcode_reg,   opcode_next;
    mode_t              mode_reg,     mode_next;
    logic [7:0]         op_low_reg,   op_low_next;
    logic [7:0]         op_high_reg,  op_high_next;
    logic [7:0]         rd_data_reg;

    logic [7:0]         store_mem [STORE_DEPTH];

    logic               in_xact;
    logic               store_we;
    logic [PTR_W-1:0]   wr_idx;
    logic [PTR_W-1:0]   ptr_inc;
    mode_t              dec_mode;

    assign in_xact  = s_tvalid && s_tready;
    assign wr_idx   = PTR_W'(s_load_address);
    assign store_we = in_xact && (s_command == CMD_LOAD)
                      && (32'(s_load_address) < STORE_DEPTH);

    // Pointer advance, wrapping at the store depth.
    assign ptr_inc  = (ptr_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign dec_mode = decode_mode(rd_data_reg);

    // Sequencer: while a fetch is in progress, one store byte is consumed per cycle.
    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        fetched_next = fetched_reg;
        opcode_next  = opcode_reg;
        mode_next    = mode_reg;
        op_low_next  = op_low_reg;
        op_high_next = op_high_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xact) begin
                    fetched_next = 1'b0;
                    opcode_next  = '0;
                    mode_next    = MODE_ZP;
                    op_low_next  = '0;
                    op_high_next = '0;
                    case (s_command)
                        CMD_FETCH: begin
                            state_next = ST_MARK;
                        end
                        CMD_RESET: begin
                            ptr_next   = '0;
                            state_next = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MARK, ST_OPC: begin
                // The end marker sends the pointer back to the start once.
                if (state_reg == ST_MARK && rd_data_reg == END_MARKER) begin
                    ptr_next   = '0;
                    state_next = ST_OPC;
                end else begin
                    ptr_next     = ptr_inc;
                    fetched_next = 1'b1;
                    mode_next    = dec_mode;
                    op_high_next = '0;
                    if (dec_mode == MODE_UNSUP) begin
                        opcode_next = IDLE_CODE;
                        op_low_next = IDLE_CODE;
                        state_next  = ST_OUT;
                    end else begin
                        opcode_next = rd_data_reg;
                        state_next  = ST_LO;
                    end
                end
            end
            ST_LO: begin
                ptr_next    = ptr_inc;
                op_low_next = rd_data_reg;
                state_next  = (mode_reg == MODE_ABS) ? ST_HI : ST_OUT;
            end
            ST_HI: begin
                ptr_next     = ptr_inc;
                op_high_next = rd_data_reg;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        fetched_reg <= fetched_next;
        opcode_reg  <= opcode_next;
        mode_reg    <= mode_next;
        op_low_reg  <= op_low_next;
        op_high_reg <= op_high_next;
    end

    // Program store: the read follows the next pointer so that the registered
    // byte always matches the pointer held in the following cycle.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[wr_idx] <= s_load_byte;
        end
        rd_data_reg <= store_mem[ptr_next];
    end

    // Handshake and output packing.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = fetched_reg;
    assign m_tdata  = {6'd0, op_high_reg, op_low_reg, mode_reg, opcode_reg};

endmodule

`default_nettype wire

@@ rtl/core/ifmd_checker.sv @@
`default_nettype none

module ifmd_checker
    import ifmd_pkg::*;
(
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_tvalid,
    input wire                  s_tready,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire                  m_tuser,
    input wire [M_TDATA_W-1:0]  m_tdata
);

    // The block handles one transaction at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while a result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after an accepted transaction");

    // A result without a fetched instruction carries all zeros.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("non-fetch result carries data");

    // An unsupported opcode is replaced by the idle code in both bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && m_tdata[9:8] == MODE_UNSUP) |->
        (m_tdata[7:0] == IDLE_CODE && m_tdata[17:10] == IDLE_CODE
         && m_tdata[25:18] == 8'd0))
        else $error("unsupported opcode not replaced");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind instruction_fetch_with_mode_decode ifmd_checker u_ifmd_checker (.*);

`default_nettype wire
